[design/dq_pkg.sv]
package dq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W  = CNT_W + 1;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned OUT_CNT_W = 5;

  localparam logic [DATA_W-1:0] EMPTY_MARK = 32'hFFFF_FFFE;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_NOP        = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic step;
    logic read;
    logic load;
  } ctrl_cmd_t;

endpackage

[design/dq_ram.sv]
module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[design/dq_datapath.sv]
module dq_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dq_pkg::ctrl_cmd_t                 cmd_i,
  input  logic [dq_pkg::CMD_W-1:0]          command_i,
  input  logic signed [dq_pkg::DATA_W-1:0]  data_value_i,
  output logic signed [dq_pkg::DATA_W-1:0]  front_value_o,
  output logic signed [dq_pkg::DATA_W-1:0]  back_value_o,
  output logic [dq_pkg::OUT_CNT_W-1:0]      entry_count_o,
  output logic                              is_empty_o,
  output logic                              is_full_o,
  output logic                              rejected_o
);

  logic [dq_pkg::PTR_W-1:0]  front_q, front_d;
  logic [dq_pkg::CNT_W-1:0]  count_q, count_d;
  logic                      rej_q, rej_d;

  logic                      full, empty;
  logic [dq_pkg::PTR_W-1:0]  front_dec, front_inc, tail_pos, back_pos;
  logic [dq_pkg::SUM_W-1:0]  tail_sum, back_sum;
  logic                      we;
  logic [dq_pkg::PTR_W-1:0]  waddr;
  logic [dq_pkg::DATA_W-1:0] rdata_a, rdata_b;
  logic [dq_pkg::CNT_W+dq_pkg::OUT_CNT_W-1:0] count_ext;

  logic signed [dq_pkg::DATA_W-1:0] front_val_q, back_val_q;
  logic [dq_pkg::OUT_CNT_W-1:0]     out_cnt_q;
  logic                             out_empty_q, out_full_q, out_rej_q;

  assign full  = (count_q == dq_pkg::CNT_W'(dq_pkg::DEPTH));
  assign empty = (count_q == '0);

  // ring pointer arithmetic, the tail sum stays below twice the depth
  assign front_dec = (front_q == '0) ? dq_pkg::PTR_W'(dq_pkg::DEPTH - 1)
                                     : front_q - 1'b1;
  assign front_inc = (front_q == dq_pkg::PTR_W'(dq_pkg::DEPTH - 1)) ? '0
                                     : front_q + 1'b1;
  assign tail_sum  = dq_pkg::SUM_W'(front_q) + dq_pkg::SUM_W'(count_q);
  assign tail_pos  = (tail_sum >= dq_pkg::SUM_W'(dq_pkg::DEPTH))
                     ? dq_pkg::PTR_W'(tail_sum - dq_pkg::SUM_W'(dq_pkg::DEPTH))
                     : dq_pkg::PTR_W'(tail_sum);
  assign back_sum  = tail_sum - 1'b1;
  assign back_pos  = (back_sum >= dq_pkg::SUM_W'(dq_pkg::DEPTH))
                     ? dq_pkg::PTR_W'(back_sum - dq_pkg::SUM_W'(dq_pkg::DEPTH))
                     : dq_pkg::PTR_W'(back_sum);

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    rej_d   = rej_q;
    we      = 1'b0;
    waddr   = front_dec;
    if (cmd_i.step) begin
      rej_d = 1'b0;
      unique case (dq_pkg::cmd_e'(command_i))
        dq_pkg::CMD_PUSH_FRONT: begin
          if (full) begin
            rej_d = 1'b1;
          end else begin
            front_d = front_dec;
            count_d = count_q + 1'b1;
            we      = 1'b1;
            waddr   = front_dec;
          end
        end
        dq_pkg::CMD_PUSH_BACK: begin
          if (full) begin
            rej_d = 1'b1;
          end else begin
            count_d = count_q + 1'b1;
            we      = 1'b1;
            waddr   = tail_pos;
          end
        end
        dq_pkg::CMD_POP_FRONT: begin
          if (empty) begin
            rej_d = 1'b1;
          end else begin
            front_d = front_inc;
            count_d = count_q - 1'b1;
          end
        end
        dq_pkg::CMD_POP_BACK: begin
          if (empty) begin
            rej_d = 1'b1;
          end else begin
            count_d = count_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      rej_q   <= 1'b0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      rej_q   <= rej_d;
    end
  end

  dq_ram #(
    .WIDTH (dq_pkg::DATA_W),
    .DEPTH (dq_pkg::DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (data_value_i),
    .re_i      (cmd_i.read),
    .raddr_a_i (front_q),
    .raddr_b_i (back_pos),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign count_ext = {{dq_pkg::OUT_CNT_W{1'b0}}, count_q};

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      front_val_q <= empty ? dq_pkg::EMPTY_MARK : rdata_a;
      back_val_q  <= empty ? dq_pkg::EMPTY_MARK : rdata_b;
      out_cnt_q   <= count_ext[dq_pkg::OUT_CNT_W-1:0];
      out_empty_q <= empty;
      out_full_q  <= full;
      out_rej_q   <= rej_q;
    end
  end

  assign front_value_o = front_val_q;
  assign back_value_o  = back_val_q;
  assign entry_count_o = out_cnt_q;
  assign is_empty_o    = out_empty_q;
  assign is_full_o     = out_full_q;
  assign rejected_o    = out_rej_q;

endmodule

[design/dq_ctrl.sv]
module dq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dq_pkg::ctrl_cmd_t cmd_o
);

  dq_pkg::state_e state_q, state_d;
  logic           out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dq_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      dq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.step = 1'b1;
          state_d    = dq_pkg::ST_READ;
        end
      end
      dq_pkg::ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = dq_pkg::ST_LOAD;
      end
      dq_pkg::ST_LOAD: begin
        // wait for the result register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load = 1'b1;
          state_d    = dq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dq_pkg::ST_IDLE;
      end
    endcase

    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_step_then_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |=> cmd_o.read)
    else $error("read did not follow an accepted word");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while held");

  a_one_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.step, cmd_o.read, cmd_o.load}))
    else $error("more than one datapath command at once");

  a_load_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> out_valid_q)
    else $error("loaded result not presented");

endmodule

[design/double_ended_queue_top.sv]
// double-ended queue of signed 32-bit values held in a ring of dq_pkg::DEPTH
// slots. each input word carries a command in s_axis_tuser (push front, push
// back, pop front, pop back, no-op; unused codes act as no-op) and a value in
// s_axis_tdata. every accepted word gives exactly one result word: front and
// back values (both -2 when empty), the count, empty and full flags, and a
// rejected flag for a push on full or a pop on empty. one word is handled at
// a time, in turn: accept and ring write, a read of front and back through
// the registered dual-read store, then the load of the result register,
// which waits while the previous result is still held. the next word is
// accepted straight after the load, even while the previous result still
// waits on m_axis_tready. the store needs no clearing after reset.
module double_ended_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] data_value
  input  logic [2:0]  s_axis_tuser,  // [2:0] command
  // result words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata   // [31:0] front_value, [63:32] back_value,
                                     // [68:64] entry_count, [69] is_empty,
                                     // [70] is_full, [71] rejected
);

  dq_pkg::ctrl_cmd_t cmd;

  logic signed [dq_pkg::DATA_W-1:0] front_value, back_value;
  logic [dq_pkg::OUT_CNT_W-1:0]     entry_count;
  logic                             is_empty, is_full, rejected;

  // sequencing of accept, read and result load
  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // pointers, count, ring store and result register
  dq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .command_i     (s_axis_tuser),
    .data_value_i  (s_axis_tdata),
    .front_value_o (front_value),
    .back_value_o  (back_value),
    .entry_count_o (entry_count),
    .is_empty_o    (is_empty),
    .is_full_o     (is_full),
    .rejected_o    (rejected)
  );

  // fields packed from the lowest bit up, no padding needed at 72 bits
  assign m_axis_tdata = {rejected, is_full, is_empty, entry_count,
                         back_value, front_value};

endmodule
